// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types and codes shared by the block bitmap allocator controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int BLOCK_W  = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 13;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic    clr_step;
        logic    rd_zero;
        logic    alloc_start;
        logic    scan_next;
        logic    alloc_take;
        logic    free_start;
        logic    seek_step;
        logic    free_clear;
        logic    res_load;
        logic    res_grant;
        status_t res_code;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic clr_last;
        logic oor;
        logic past_limit;
        logic has_free;
        logic seek_done;
        logic bit_set;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a one-bit-per-block use map held in a
// word-wide memory, with a controller and a datapath.
// ----------------------------------------------------------------------------
//  channel   direction  signals                              handshake
//  request   in         opcode, block_number                 start && !busy
//  result    out        allocated_block, status              done, one cycle
//  config    in         cfg_wr_data                          cfg_wr_en
//
//  An allocate scans the map words in order, up to the last word holding
//  blocks below the block count, paced by the one-word-per-cycle memory read.
//  A free seeks its block's word (block_number / MAP_WORD_BITS), then checks
//  and clears the bit; a free out of range is answered from idle. Results
//  are registered and cannot be stalled by the receiver. After reset, a
//  clearing pass zeroes the map word by word with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator #(
    parameter int MAX_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire                            opcode,
    input  wire  [bba_pkg::BLOCK_W-1:0]    block_number,
    output logic                           done,
    output logic [bba_pkg::BLOCK_W-1:0]    allocated_block,
    output logic [bba_pkg::STATUS_W-1:0]   status,
    input  wire                            cfg_wr_en,
    input  wire  [bba_pkg::CFG_W-1:0]      cfg_wr_data
);

    bba_pkg::ctl_cmd_t cmd;
    bba_pkg::dp_stat_t stat;

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    bba_datapath #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .block_number    (block_number),
        .cmd             (cmd),
        .stat            (stat),
        .done            (done),
        .allocated_block (allocated_block),
        .status          (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Use map memory, block count register, word scan with lowest-free-bit
// search, block-to-word seek and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath #(
    parameter int MAX_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_wr_en,
    input  wire  [bba_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire  [bba_pkg::BLOCK_W-1:0]      block_number,
    input  bba_pkg::ctl_cmd_t                cmd,
    output bba_pkg::dp_stat_t                stat,
    output logic                             done,
    output logic [bba_pkg::BLOCK_W-1:0]      allocated_block,
    output logic [bba_pkg::STATUS_W-1:0]     status
);

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int RD_W      = $clog2(MAP_WORDS + 1);
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int CNT_W     = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
    localparam int AW        = (CNT_W > bba_pkg::CFG_W) ? CNT_W : bba_pkg::CFG_W;

    localparam logic [AW-1:0]            W_AW      = AW'(MAP_WORD_BITS);
    localparam logic [AW-1:0]            MAXB_AW   = AW'(MAX_BLOCKS);
    localparam logic [RD_W-1:0]          LAST_WORD = RD_W'(MAP_WORDS - 1);
    localparam logic [MAP_WORD_BITS-1:0] ONE_W     = MAP_WORD_BITS'(1);

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];

    logic [bba_pkg::CFG_W-1:0]    cfg_reg;
    logic [RD_W-1:0]              rd_word_reg,  rd_word_next;
    logic [WIDX_W-1:0]            chk_word_reg, chk_word_next;
    logic [AW-1:0]                chk_base_reg, chk_base_next;
    logic [AW-1:0]                offset_reg,   offset_next;
    logic [MAP_WORD_BITS-1:0]     rdata_reg;
    logic                         done_reg;
    logic [bba_pkg::BLOCK_W-1:0]  res_block_reg;
    bba_pkg::status_t             res_status_reg;

    logic [WIDX_W-1:0]            rd_idx;
    logic [AW-1:0]                limit;
    logic [AW-1:0]                rem;
    logic [MAP_WORD_BITS-1:0]     span_mask;
    logic [MAP_WORD_BITS-1:0]     free_bits;
    logic [MAP_WORD_BITS-1:0]     take_bit;
    logic [BIT_W-1:0]             take_pos;
    logic [AW-1:0]                grant;
    logic [MAP_WORD_BITS-1:0]     free_bit;
    logic                         mem_we;
    logic [WIDX_W-1:0]            wr_idx;
    logic [MAP_WORD_BITS-1:0]     wr_data;

    assign rd_idx = rd_word_reg[WIDX_W-1:0];

    // Counts above the map size behave as the map size.
    assign limit = (AW'(cfg_reg) > MAXB_AW) ? MAXB_AW : AW'(cfg_reg);

    // Lowest free block of the word under test, below the block count.
    assign rem = limit - chk_base_reg;

    always_comb
    begin
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            span_mask[i] = (AW'(i) < rem);
        end
    end

    assign free_bits = ~rdata_reg & span_mask;
    assign take_bit  = free_bits & (~free_bits + ONE_W);

    always_comb
    begin
        take_pos = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (take_bit[i])
            begin
                take_pos = take_pos | BIT_W'(i);
            end
        end
    end

    assign grant = chk_base_reg + AW'(take_pos);

    always_comb
    begin
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            free_bit[i] = (offset_reg[BIT_W-1:0] == BIT_W'(i));
        end
    end

    assign stat.clr_last   = (rd_word_reg == LAST_WORD);
    assign stat.oor        = (AW'(block_number) >= limit);
    assign stat.past_limit = (chk_base_reg >= limit);
    assign stat.has_free   = |free_bits;
    assign stat.seek_done  = (offset_reg < W_AW);
    assign stat.bit_set    = |(rdata_reg & free_bit);

    // Write port of the use map.
    always_comb
    begin
        mem_we  = 1'b0;
        wr_idx  = rd_idx;
        wr_data = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.alloc_take)
        begin
            mem_we  = 1'b1;
            wr_idx  = chk_word_reg;
            wr_data = rdata_reg | take_bit;
        end
        else if (cmd.free_clear)
        begin
            mem_we  = 1'b1;
            wr_data = rdata_reg & ~free_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[wr_idx] <= wr_data;
        end
        rdata_reg <= map_mem[rd_idx];
    end

    always_comb
    begin
        rd_word_next  = rd_word_reg;
        chk_word_next = chk_word_reg;
        chk_base_next = chk_base_reg;
        offset_next   = offset_reg;
        if (cmd.rd_zero)
        begin
            rd_word_next = '0;
        end
        else if (cmd.alloc_start)
        begin
            rd_word_next = RD_W'(1);
        end
        else if (cmd.clr_step || cmd.scan_next || cmd.seek_step)
        begin
            rd_word_next = rd_word_reg + RD_W'(1);
        end
        if (cmd.alloc_start)
        begin
            chk_word_next = '0;
            chk_base_next = '0;
        end
        else if (cmd.scan_next)
        begin
            chk_word_next = rd_idx;
            chk_base_next = chk_base_reg + W_AW;
        end
        if (cmd.free_start)
        begin
            offset_next = AW'(block_number);
        end
        else if (cmd.seek_step)
        begin
            offset_next = offset_reg - W_AW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= bba_pkg::CFG_RESET;
            rd_word_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            rd_word_reg <= rd_word_next;
            done_reg    <= cmd.res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_word_reg <= chk_word_next;
        chk_base_reg <= chk_base_next;
        offset_reg   <= offset_next;
        if (cmd.res_load)
        begin
            res_block_reg  <= cmd.res_grant ? grant[bba_pkg::BLOCK_W-1:0] : '0;
            res_status_reg <= cmd.res_code;
        end
    end

    assign done            = done_reg;
    assign allocated_block = res_block_reg;
    assign status          = res_status_reg;

    a_take_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_take |-> $onehot(take_bit))
        else $error("allocation does not select exactly one free bit");

    a_grant_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_take |-> (grant < limit))
        else $error("granted block lies at or above the block count");

    a_seek_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seek_step |-> (rd_word_reg < LAST_WORD))
        else $error("block seek ran past the last map word");

endmodule

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller of the block bitmap allocator: clearing pass after reset,
// allocate word scan and free seek, check and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                opcode,
    input  bba_pkg::dp_stat_t  stat,
    output bba_pkg::ctl_cmd_t  cmd,
    output logic               busy
);

    typedef enum logic [4:0]
    {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_ASCAN  = 5'b00100,
        S_FSEEK  = 5'b01000,
        S_FCHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = bba_pkg::ST_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.rd_zero = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == bba_pkg::OP_ALLOC)
                    begin
                        cmd.alloc_start = 1'b1;
                        state_next      = S_ASCAN;
                    end
                    else if (stat.oor)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = bba_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd.free_start = 1'b1;
                        cmd.rd_zero    = 1'b1;
                        state_next     = S_FSEEK;
                    end
                end
            end
            S_ASCAN:
            begin
                if (stat.past_limit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = bba_pkg::ST_FULL;
                    cmd.rd_zero  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.has_free)
                begin
                    cmd.alloc_take = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_grant  = 1'b1;
                    cmd.rd_zero    = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_FSEEK:
            begin
                if (stat.seek_done)
                begin
                    state_next = S_FCHECK;
                end
                else
                begin
                    cmd.seek_step = 1'b1;
                end
            end
            S_FCHECK:
            begin
                cmd.res_load = 1'b1;
                cmd.rd_zero  = 1'b1;
                if (stat.bit_set)
                begin
                    cmd.free_clear = 1'b1;
                end
                else
                begin
                    cmd.res_code = bba_pkg::ST_DOUBLE_FREE;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // The clearing pass runs once, straight after reset.
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clearing pass re-entered outside reset");

endmodule

`default_nettype wire

// ===== bench/bba_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the request, result and configuration ports of the block bitmap
// allocator, keeps its own copy of the use map and block count, works out
// the result of every accepted request and compares it with what comes back.
// ----------------------------------------------------------------------------

module bba_checker
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire                            busy,
    input  wire                            opcode,
    input  wire  [bba_pkg::BLOCK_W-1:0]    block_number,
    input  wire                            done,
    input  wire  [bba_pkg::BLOCK_W-1:0]    allocated_block,
    input  wire  [bba_pkg::STATUS_W-1:0]   status,
    input  wire                            cfg_wr_en,
    input  wire  [bba_pkg::CFG_W-1:0]      cfg_wr_data,
    output int                             fail_count,
    output int                             pending,
    output int                             ok_seen,
    output int                             full_seen,
    output int                             dfree_seen,
    output int                             range_seen
);

    localparam int CAPACITY    = 4096;

    typedef struct packed
    {
        logic [bba_pkg::BLOCK_W-1:0] block;
        bba_pkg::status_t            code;
    } grant_t;

    grant_t                     grant_q[$];
    logic [CAPACITY-1:0]        used_map;
    logic [bba_pkg::CFG_W-1:0]  count_reg;

    task automatic flag(input string msg);
        fail_count++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // Counts above the capacity behave as the capacity itself.
    function automatic int effective_count();
        return (count_reg > CAPACITY) ? CAPACITY : int'(count_reg);
    endfunction

    // First-fit allocate or free against the local use map.
    task automatic predict_grant(input logic op, input logic [bba_pkg::BLOCK_W-1:0] blk,
                                 output grant_t res);
        int lim;
        int b;
        bit found;
        lim       = effective_count();
        found     = 1'b0;
        res.block = '0;
        if (op == bba_pkg::OP_ALLOC)
        begin
            for (b = 0; b < lim && !found; b++)
            begin
                if (!used_map[b])
                begin
                    used_map[b] = 1'b1;
                    res.block   = b[bba_pkg::BLOCK_W-1:0];
                    found       = 1'b1;
                end
            end
            res.code = found ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
        end
        else if (int'(blk) >= lim)
            res.code = bba_pkg::ST_RANGE;
        else if (!used_map[blk])
            res.code = bba_pkg::ST_DOUBLE_FREE;
        else
        begin
            used_map[blk] = 1'b0;
            res.code      = bba_pkg::ST_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t got;
        if (!rst_n)
        begin
            used_map   = '0;
            count_reg  = bba_pkg::CFG_RESET;
            grant_q.delete();
            fail_count = 0;
            pending    = 0;
            ok_seen    = 0;
            full_seen  = 0;
            dfree_seen = 0;
            range_seen = 0;
        end
        else
        begin
            // The result of an earlier transaction is retired before a new
            // request taken at the same edge is predicted.
            if (done === 1'b1)
            begin
                case (status)
                    bba_pkg::ST_OK:          ok_seen++;
                    bba_pkg::ST_FULL:        full_seen++;
                    bba_pkg::ST_DOUBLE_FREE: dfree_seen++;
                    default:                 range_seen++;
                endcase
                if (grant_q.size() == 0)
                    flag($sformatf("result block %0d status %0d with nothing outstanding",
                                   allocated_block, status));
                else
                begin
                    want = grant_q.pop_front();
                    if (allocated_block !== want.block)
                        flag($sformatf("allocated_block expected %0d got %0d",
                                       want.block, allocated_block));
                    if (status !== want.code)
                        flag($sformatf("status expected %0d got %0d", want.code, status));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                predict_grant(opcode, block_number, got);
                grant_q.push_back(got);
            end
            if (cfg_wr_en === 1'b1)
                count_reg = cfg_wr_data;
            pending = grant_q.size();
        end
    end

endmodule

// ===== bench/tb_block_bitmap_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator
// Drives allocate and free requests into the block bitmap allocator over a
// range of block counts, with bursts and gaps on the request side, and lets
// the checker predict and compare every result.
// ----------------------------------------------------------------------------

module tb_block_bitmap_allocator;

    localparam int BLOCK_W  = bba_pkg::BLOCK_W;
    localparam int STATUS_W = bba_pkg::STATUS_W;
    localparam int CFG_W    = bba_pkg::CFG_W;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 118;
    localparam int MAX_BLOCK     = 4095;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    bba_pkg::opcode_t     opcode       = bba_pkg::OP_ALLOC;
    logic [BLOCK_W-1:0]   block_number = '0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;

    wire                  busy;
    wire                  done;
    wire  [BLOCK_W-1:0]   allocated_block;
    wire  [STATUS_W-1:0]  status;

    int fail_count;
    int pending;
    int ok_seen;
    int full_seen;
    int dfree_seen;
    int range_seen;

    int      quiet_cycles = 0;
    int      alloc_sent   = 0;
    int      free_sent    = 0;
    int      settings_run = 0;
    int      burst_left   = 0;
    bit      steady       = 1'b0;
    int      count_now    = 4096;

    always #6 clk = ~clk;

    block_bitmap_allocator dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .block_number    (block_number),
        .done            (done),
        .allocated_block (allocated_block),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    bba_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .block_number    (block_number),
        .done            (done),
        .allocated_block (allocated_block),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .ok_seen         (ok_seen),
        .full_seen       (full_seen),
        .dfree_seen      (dfree_seen),
        .range_seen      (range_seen)
    );

    // Any cycle that accepts a request or delivers a result resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Random pause with start low; the request fields carry noise meanwhile.
    task automatic pause_sender();
        int n;
        n = $urandom_range(1, 15);
        repeat (n)
        begin
            @(negedge clk);
            start        <= 1'b0;
            opcode       <= bba_pkg::opcode_t'($urandom_range(0, 1));
            block_number <= BLOCK_W'($urandom);
        end
    endtask

    task automatic send(input bba_pkg::opcode_t op, input logic [BLOCK_W-1:0] blk);
        if (!steady && burst_left == 0)
        begin
            pause_sender();
            burst_left = $urandom_range(1, 12);
        end
        @(negedge clk);
        start        <= 1'b1;
        opcode       <= op;
        block_number <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (op == bba_pkg::OP_ALLOC)
            alloc_sent++;
        else
            free_sent++;
    endtask

    // Hold off until every outstanding result has come back and the block is idle.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        count_now = int'(value);
        settings_run++;
    endtask

    task automatic random_request(input int alloc_pct);
        int lim;
        int hot;
        int r;
        lim = (count_now > 4096) ? 4096 : count_now;
        hot = alloc_sent + 8;
        if (hot > lim - 1)
            hot = lim - 1;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            send(bba_pkg::OP_ALLOC, BLOCK_W'($urandom));
        else if (r < alloc_pct + (100 - alloc_pct) * 7 / 10 && lim > 0)
            send(bba_pkg::OP_FREE, BLOCK_W'($urandom_range(0, hot)));
        else
        begin
            case ($urandom_range(0, 3))
                0:       send(bba_pkg::OP_FREE, BLOCK_W'((lim > 0) ? lim - 1 : 0));
                1:       send(bba_pkg::OP_FREE, BLOCK_W'((lim > MAX_BLOCK) ? MAX_BLOCK : lim));
                2:       send(bba_pkg::OP_FREE, BLOCK_W'(MAX_BLOCK));
                default: send(bba_pkg::OP_FREE, BLOCK_W'($urandom));
            endcase
        end
    endtask

    initial
    begin
        int phase_counts[12];
        int p;
        int i;
        int alloc_pct;

        phase_counts = '{64, 1, 130, 8191, 0, 65, 4096, 17, 200, 4095, 128, 3};
        phase_counts[$urandom_range(0, 11)] = $urandom_range(1, 4096);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty map at the full default count.
        send(bba_pkg::OP_FREE, 0);
        send(bba_pkg::OP_FREE, BLOCK_W'(MAX_BLOCK));
        send(bba_pkg::OP_ALLOC, BLOCK_W'(MAX_BLOCK));
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_FREE, 0);
        send(bba_pkg::OP_ALLOC, 12'hA5C);
        send(bba_pkg::OP_FREE, 1);
        send(bba_pkg::OP_FREE, 0);

        // A zero count allows neither allocation nor any free.
        write_count(0);
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_FREE, 0);
        send(bba_pkg::OP_FREE, BLOCK_W'(MAX_BLOCK));

        // A count above capacity behaves as the full capacity.
        write_count(13'h1FFF);
        send(bba_pkg::OP_FREE, BLOCK_W'(MAX_BLOCK));
        send(bba_pkg::OP_ALLOC, 0);

        // One block only, already taken.
        write_count(1);
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_FREE, 1);
        send(bba_pkg::OP_FREE, 0);
        send(bba_pkg::OP_ALLOC, 0);

        // Fill a three-block pool, then run out.
        write_count(3);
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_ALLOC, 0);
        send(bba_pkg::OP_FREE, 2);
        send(bba_pkg::OP_ALLOC, 0);

        for (p = 0; p < 12; p++)
        begin
            write_count(CFG_W'(phase_counts[p]));
            steady = (p % 4 == 2);
            burst_left = 0;
            case ($urandom_range(0, 2))
                0:       alloc_pct = 30;
                1:       alloc_pct = 50;
                default: alloc_pct = 70;
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                random_request(alloc_pct);
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d allocate and %0d free transactions across %0d block-count settings.",
                 alloc_sent, free_sent, settings_run);
        $display("Results seen: %0d ok, %0d out of blocks, %0d double free, %0d out of range.",
                 ok_seen, full_seen, dfree_seen, range_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
